/* hw/rtl/rpr_pkg.sv */
// Shared types, constants and the arctangent table for the rotary position rotator.
// Used by the front end, the queue, the CORDIC back end and the top level.
// No dependencies.
package rpr_pkg;

    localparam int HEAD_PAIRS_DEF    = 64;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DATA_WIDTH_DEF    = 16;

    localparam int IDX_W     = 6;
    localparam int FREQ_W    = 32;
    localparam int POS_W     = 16;
    localparam int PHASE_W   = 32;
    localparam int TBL_MAX   = 64;
    localparam int RESID_W   = 30;
    localparam int QUAD_W    = 2;
    localparam int XW        = 34;
    localparam int ZW        = 33;
    localparam int FRAC_BITS = 30;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [PHASE_W-1:0]   EIGHTH_TURN  = 32'h2000_0000;
    localparam logic signed [XW-1:0] INV_GAIN_Q30 = 34'sd652032874;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_ROTATE = 1'b1
    } op_t;

    typedef enum logic [QUAD_W-1:0]
    {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turns(input int unsigned stage);
        logic [31:0] a;
        unique case (stage)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

/* hw/rtl/rpr_front.sv */
// Front end: accepts items, writes the frequency table on loads, reads it on
// rotates and forms the phase, quadrant and residual angle. Uses rpr_pkg.
module rpr_front
    import rpr_pkg::*;
#(
    parameter int HEAD_PAIRS = HEAD_PAIRS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [IDX_W-1:0]             freq_index,
    input  logic [FREQ_W-1:0]            freq_value,
    input  logic [POS_W-1:0]             position,
    input  logic signed [DATA_WIDTH-1:0] first_value,
    input  logic signed [DATA_WIDTH-1:0] second_value,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [QUAD_W-1:0]            q_quad,
    output logic [RESID_W-1:0]           q_resid,
    output logic [DATA_WIDTH-1:0]        q_first,
    output logic [DATA_WIDTH-1:0]        q_second
);

    localparam int TBL_DEPTH = (HEAD_PAIRS < TBL_MAX) ? HEAD_PAIRS : TBL_MAX;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    logic [FREQ_W-1:0]           tbl_mem [TBL_DEPTH];
    logic [FREQ_W-1:0]           rdata_reg;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_ok_reg;
    logic [POS_W-1:0]            s1_pos_reg;
    logic [DATA_WIDTH-1:0]       s1_first_reg;
    logic [DATA_WIDTH-1:0]       s1_second_reg;

    logic                        s2_valid_reg;
    logic [PHASE_W-1:0]          s2_phase_reg, s2_phase_next;
    logic [DATA_WIDTH-1:0]       s2_first_reg;
    logic [DATA_WIDTH-1:0]       s2_second_reg;

    logic                        front_en;
    logic                        accept;
    logic                        is_rot;
    logic                        idx_ok;
    logic [TBL_AW-1:0]           addr;
    logic [FREQ_W-1:0]           freq_eff;
    logic [POS_W+FREQ_W-1:0]     prod;
    logic [PHASE_W-1:0]          shifted;

    // hold the whole front while the last stage cannot hand over
    assign front_en = !s2_valid_reg || q_ready;
    assign in_ready = front_en;
    assign accept   = in_valid && front_en;
    assign is_rot   = (op_t'(operation) == OP_ROTATE);
    assign idx_ok   = (int'(freq_index) < HEAD_PAIRS);
    assign addr     = freq_index[TBL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && !is_rot && idx_ok)
        begin
            tbl_mem[addr] <= freq_value;
        end
        if (accept && is_rot && idx_ok)
        begin
            rdata_reg <= tbl_mem[addr];
        end
    end

    assign s1_valid_next = accept && is_rot;

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_ok_reg     <= idx_ok;
            s1_pos_reg    <= position;
            s1_first_reg  <= first_value;
            s1_second_reg <= second_value;
        end
    end

    // an index beyond the head selects frequency zero
    assign freq_eff      = s1_ok_reg ? rdata_reg : '0;
    assign prod          = s1_pos_reg * freq_eff;
    assign s2_phase_next = prod[PHASE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            s2_phase_reg  <= s2_phase_next;
            s2_first_reg  <= s1_first_reg;
            s2_second_reg <= s1_second_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // centre each quadrant on its axis; residual lies in [-1/8, 1/8) turn
    assign shifted  = s2_phase_reg + EIGHTH_TURN;
    assign q_valid  = s2_valid_reg;
    assign q_quad   = shifted[PHASE_W-1:PHASE_W-QUAD_W];
    assign q_resid  = {~shifted[RESID_W-1], shifted[RESID_W-2:0]};
    assign q_first  = s2_first_reg;
    assign q_second = s2_second_reg;

endmodule

/* hw/rtl/rpr_queue.sv */
// Small register queue between the front end and the CORDIC back end.
// Uses rpr_pkg for the default depth.
module rpr_queue
    import rpr_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_mem [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = buf_mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hw/rtl/rpr_back.sv */
// Back end: unrolled CORDIC, quadrant rotation, pair rotation with rounding
// and saturation, and a credit-guarded result buffer. Uses rpr_pkg.
module rpr_back
    import rpr_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [QUAD_W-1:0]            q_quad,
    input  logic [RESID_W-1:0]           q_resid,
    input  logic [DATA_WIDTH-1:0]        q_first,
    input  logic [DATA_WIDTH-1:0]        q_second,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] first_rotated,
    output logic signed [DATA_WIDTH-1:0] second_rotated
);

    localparam int N     = CORDIC_STAGES;
    localparam int LAT   = N + 4;
    localparam int CAP   = LAT + 2;
    localparam int FPW   = $clog2(CAP);
    localparam int CNTW  = $clog2(CAP + 1);
    localparam int PW    = DATA_WIDTH + XW;
    localparam int ACC_W = PW + 1;
    localparam int VW    = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(EIGHTH_TURN);

    logic signed [XW-1:0]         x_reg [N+1];
    logic signed [XW-1:0]         y_reg [N+1];
    logic signed [ZW-1:0]         z_reg [N+1];
    logic [QUAD_W-1:0]            qd_reg [N+1];
    logic signed [DATA_WIDTH-1:0] a_reg [N+1];
    logic signed [DATA_WIDTH-1:0] b_reg [N+1];

    logic signed [XW-1:0]         c_reg, s_reg;
    logic signed [XW-1:0]         c_next, s_next;
    logic signed [DATA_WIDTH-1:0] a_q_reg, b_q_reg;
    logic signed [PW-1:0]         pac_reg, pbs_reg, pas_reg, pbc_reg;
    logic signed [ACC_W-1:0]      acc1_reg, acc2_reg;
    logic signed [ACC_W-1:0]      rnd1, rnd2;
    logic signed [VW-1:0]         v1, v2;
    logic [DATA_WIDTH-1:0]        sat1, sat2;

    logic [LAT-1:0]               vld_reg;
    logic [CNTW-1:0]              cnt_reg, cnt_next;
    logic                         issue;

    logic [DATA_WIDTH-1:0]        of_mem [CAP];
    logic [DATA_WIDTH-1:0]        os_mem [CAP];
    logic [FPW-1:0]               wp_reg, wp_next;
    logic [FPW-1:0]               rp_reg, rp_next;
    logic [CNTW-1:0]              fc_reg, fc_next;
    logic                         wr;
    logic                         pop;

    function automatic logic [DATA_WIDTH-1:0] saturate(input logic signed [VW-1:0] v);
        logic [DATA_WIDTH-1:0] r;
        if ((&v[VW-1:DATA_WIDTH-1]) || !(|v[VW-1:DATA_WIDTH-1]))
        begin
            r = v[DATA_WIDTH-1:0];
        end
        else if (v[VW-1])
        begin
            r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    // credits cover every item in the pipeline plus every buffered result
    assign q_ready = (cnt_reg < CNTW'(CAP));
    assign issue   = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        x_reg[0]  <= INV_GAIN_Q30;
        y_reg[0]  <= '0;
        z_reg[0]  <= ZW'($signed(q_resid));
        qd_reg[0] <= q_quad;
        a_reg[0]  <= q_first;
        b_reg[0]  <= q_second;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turns(i));

        always_ff @(posedge clk)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            qd_reg[i+1] <= qd_reg[i];
            a_reg[i+1]  <= a_reg[i];
            b_reg[i+1]  <= b_reg[i];
        end
    end

    // turn the vector by whole quarter turns
    always_comb
    begin
        unique case (quad_t'(qd_reg[N]))
            QUAD_0:
            begin
                c_next = x_reg[N];
                s_next = y_reg[N];
            end
            QUAD_1:
            begin
                c_next = -y_reg[N];
                s_next = x_reg[N];
            end
            QUAD_2:
            begin
                c_next = -x_reg[N];
                s_next = -y_reg[N];
            end
            QUAD_3:
            begin
                c_next = y_reg[N];
                s_next = -x_reg[N];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        s_reg    <= s_next;
        a_q_reg  <= a_reg[N];
        b_q_reg  <= b_reg[N];
        pac_reg  <= a_q_reg * c_reg;
        pbs_reg  <= b_q_reg * s_reg;
        pas_reg  <= a_q_reg * s_reg;
        pbc_reg  <= b_q_reg * c_reg;
        acc1_reg <= ACC_W'(pac_reg) - ACC_W'(pbs_reg);
        acc2_reg <= ACC_W'(pas_reg) + ACC_W'(pbc_reg);
    end

    assign rnd1 = acc1_reg + ROUND_HALF;
    assign rnd2 = acc2_reg + ROUND_HALF;
    assign v1   = VW'(rnd1 >>> FRAC_BITS);
    assign v2   = VW'(rnd2 >>> FRAC_BITS);
    assign sat1 = saturate(v1);
    assign sat2 = saturate(v2);

    assign wr  = vld_reg[LAT-1];
    assign pop = out_valid && out_ready;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        fc_next  = fc_reg;
        cnt_next = cnt_reg;
        if (wr)
        begin
            wp_next = (wp_reg == FPW'(CAP - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == FPW'(CAP - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (wr && !pop)
        begin
            fc_next = fc_reg + 1'b1;
        end
        else if (pop && !wr)
        begin
            fc_next = fc_reg - 1'b1;
        end
        if (issue && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !issue)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            of_mem[wp_reg] <= sat1;
            os_mem[wp_reg] <= sat2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
            fc_reg  <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], issue};
            cnt_reg <= cnt_next;
            fc_reg  <= fc_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    assign out_valid      = (fc_reg != '0);
    assign first_rotated  = of_mem[rp_reg];
    assign second_rotated = os_mem[rp_reg];

endmodule

/* hw/rtl/rotary_position_rotate.sv */
// Rotary position rotator, top level: front end, queue and CORDIC back end.
// Uses rpr_pkg, rpr_front, rpr_queue and rpr_back.
//
// Takes one item per cycle while in_ready is high, loads and rotates alike.
// A load writes one entry of the inverse frequency table (min(HEAD_PAIRS, 64)
// entries, one port) and gives no result; a rotate reads an entry that must
// have been loaded before. A rotate result passes two front stages (table
// read, phase multiply), the queue, one load stage, one stage per CORDIC
// iteration, then quadrant turn, multiply and sum stages ahead of the result
// buffer. The result buffer holds CORDIC_STAGES + 6 results, so a stalled
// output stops input only once the pipeline and buffer are full; there is no
// clearing pass after reset.
module rotary_position_rotate
    import rpr_pkg::*;
#(
    parameter int HEAD_PAIRS    = HEAD_PAIRS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [IDX_W-1:0]             freq_index,
    input  logic [FREQ_W-1:0]            freq_value,
    input  logic [POS_W-1:0]             position,
    input  logic signed [DATA_WIDTH-1:0] first_value,
    input  logic signed [DATA_WIDTH-1:0] second_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] first_rotated,
    output logic signed [DATA_WIDTH-1:0] second_rotated
);

    localparam int QW = QUAD_W + RESID_W + 2 * DATA_WIDTH;

    logic                  fq_valid, fq_ready;
    logic [QUAD_W-1:0]     fq_quad;
    logic [RESID_W-1:0]    fq_resid;
    logic [DATA_WIDTH-1:0] fq_first, fq_second;
    logic [QW-1:0]         push_data, pop_data;

    logic                  bq_valid, bq_ready;
    logic [QUAD_W-1:0]     bq_quad;
    logic [RESID_W-1:0]    bq_resid;
    logic [DATA_WIDTH-1:0] bq_first, bq_second;

    rpr_front #(
        .HEAD_PAIRS (HEAD_PAIRS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .freq_index   (freq_index),
        .freq_value   (freq_value),
        .position     (position),
        .first_value  (first_value),
        .second_value (second_value),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_quad       (fq_quad),
        .q_resid      (fq_resid),
        .q_first      (fq_first),
        .q_second     (fq_second)
    );

    assign push_data = {fq_quad, fq_resid, fq_first, fq_second};

    rpr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (push_data),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (pop_data)
    );

    assign {bq_quad, bq_resid, bq_first, bq_second} = pop_data;

    rpr_back #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (bq_valid),
        .q_ready        (bq_ready),
        .q_quad         (bq_quad),
        .q_resid        (bq_resid),
        .q_first        (bq_first),
        .q_second       (bq_second),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_rotated  (first_rotated),
        .second_rotated (second_rotated)
    );

endmodule
